// ----- sv/tabular_q_learning_update_defines.svh -----
// Assertion macros shared by the block's RTL.
`ifndef TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH
`define TABULAR_Q_LEARNING_UPDATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tql assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TQL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tql assertion failed");

`endif

// ----- sv/tql_pkg.sv -----
package tql_pkg;

  localparam int NUM_STATES_DEF  = 64;
  localparam int NUM_ACTIONS_DEF = 4;

  localparam int VAL_W       = 32;
  localparam int COEF_W      = 17;
  localparam int STATE_IDX_W = 6;
  localparam int FORCED_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_W      = 16;

  localparam logic [COEF_W-1:0] LEARN_RATE_RESET = COEF_W'(6554);
  localparam logic [COEF_W-1:0] DISCOUNT_RESET   = COEF_W'(58982);

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE = 2'd0,
    CFG_DISCOUNT   = 2'd1
  } cfg_reg_t;

endpackage

// ----- sv/tabular_q_learning_update.sv -----
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    state_index reward terminal force_action
//                                             forced_action
// out       output     out_valid / out_ready  chosen_action row_maximum updated_value saturated
// cfg       input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// Each accepted item is processed by a row scan through the single read port of the value
// table, followed by two registered multiplies.
// After reset all NUM_STATES * NUM_ACTIONS table entries are cleared, one entry a cycle,
// during which no item is accepted; configuration writes are always taken.
// A new item is accepted while the previous result waits; the write-back stalls only
// while the output register is still full.
`include "tabular_q_learning_update_defines.svh"

module tabular_q_learning_update #(
  parameter int NUM_STATES  = tql_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [tql_pkg::STATE_IDX_W-1:0]             state_index,
  input  logic signed [tql_pkg::VAL_W-1:0]            reward,
  input  logic                                        terminal,
  input  logic                                        force_action,
  input  logic [tql_pkg::FORCED_W-1:0]                forced_action,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [$clog2(NUM_ACTIONS)-1:0]              chosen_action,
  output logic signed [tql_pkg::VAL_W-1:0]            row_maximum,
  output logic signed [tql_pkg::VAL_W-1:0]            updated_value,
  output logic                                        saturated,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [tql_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [tql_pkg::COEF_W-1:0]                  cfg_data
);
  import tql_pkg::*;

  localparam int DEPTH    = NUM_STATES * NUM_ACTIONS;
  localparam int TW       = $clog2(DEPTH);
  localparam int SW       = $clog2(NUM_STATES);
  localparam int AW       = $clog2(NUM_ACTIONS);
  localparam int STATE_CODES  = 1 << STATE_IDX_W;
  localparam int FORCED_CODES = 1 << FORCED_W;
  localparam int P1_W     = COEF_W + 1 + VAL_W;
  localparam int R1_W     = P1_W - FRAC_W;
  localparam int DIFF_W   = R1_W + 2;
  localparam int P2_W     = COEF_W + 1 + DIFF_W;
  localparam int DELTA_W  = P2_W - FRAC_W;
  localparam int NV_W     = DELTA_W + 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_MUL_T, ST_ADD_T, ST_MUL_D, ST_RND, ST_WB
  } state_t;

  state_t                    state;
  logic [TW-1:0]             clr_addr;
  logic [TW-1:0]             last_addr;
  logic [TW-1:0]             row_base;
  logic [AW-1:0]             scan_cnt;
  logic                      rd_row_valid;
  logic [AW-1:0]             rd_row_act;
  logic [COEF_W-1:0]         learn_rate;
  logic [COEF_W-1:0]         discount;

  logic signed [VAL_W-1:0]   reward_q;
  logic                      terminal_q;
  logic                      force_q;
  logic [AW-1:0]             forced_q;
  logic signed [VAL_W-1:0]   old_val;
  logic signed [VAL_W-1:0]   rowmax;
  logic [AW-1:0]             best;
  logic signed [P1_W-1:0]    prod1;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [P2_W-1:0]    prod2;
  logic signed [DELTA_W-1:0] delta;

  logic [SW-1:0]             state_mod [STATE_CODES];
  logic [AW-1:0]             forced_mod [FORCED_CODES];

  logic                      tbl_we;
  logic [TW-1:0]             tbl_waddr;
  logic signed [VAL_W-1:0]   tbl_wdata;
  logic [TW-1:0]             tbl_raddr;
  logic signed [VAL_W-1:0]   tbl_rdata;

  logic                      in_acc;
  logic                      wb_go;
  logic [TW-1:0]             row_base_next;
  logic [COEF_W-1:0]         gam;
  logic signed [P1_W-1:0]    rsum1;
  logic signed [R1_W-1:0]    r1;
  logic signed [P2_W-1:0]    rsum2;
  logic signed [NV_W-1:0]    nv;
  logic                      sat_hi;
  logic                      sat_lo;
  logic signed [VAL_W-1:0]   nv_sat;

  for (genvar i = 0; i < STATE_CODES; i++) begin : g_state_mod
    assign state_mod[i] = SW'(i % NUM_STATES);
  end

  for (genvar j = 0; j < FORCED_CODES; j++) begin : g_forced_mod
    assign forced_mod[j] = AW'(j % NUM_ACTIONS);
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign wb_go     = (state == ST_WB) && (!out_valid || out_ready);

  assign row_base_next = TW'(TW'(state_mod[state_index]) * TW'(NUM_ACTIONS));

  assign gam   = terminal_q ? '0 : discount;
  assign rsum1 = prod1 + P1_W'(32768);
  assign r1    = rsum1[P1_W-1:FRAC_W];
  assign rsum2 = prod2 + P2_W'(32768);
  assign nv    = NV_W'(old_val) + NV_W'(delta);
  assign sat_hi = nv > NV_W'(VAL_MAX);
  assign sat_lo = nv < NV_W'(VAL_MIN);
  assign nv_sat = sat_hi ? VAL_MAX : (sat_lo ? VAL_MIN : nv[VAL_W-1:0]);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = last_addr;
    tbl_wdata = nv_sat;
    tbl_raddr = last_addr;
    case (state)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_addr;
        tbl_wdata = '0;
      end
      ST_SCAN: begin
        tbl_raddr = row_base + TW'(scan_cnt);
      end
      ST_WB: begin
        tbl_we = wb_go;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  tql_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (TW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      last_addr    <= '0;
      rd_row_valid <= 1'b0;
      out_valid    <= 1'b0;
      learn_rate   <= LEARN_RATE_RESET;
      discount     <= DISCOUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEARN_RATE: learn_rate <= cfg_data;
          CFG_DISCOUNT:   discount   <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready && !wb_go) begin
        out_valid <= 1'b0;
      end

      rd_row_valid <= (state == ST_SCAN);
      rd_row_act   <= scan_cnt;
      if (rd_row_valid) begin
        if ((rd_row_act == '0) || (tbl_rdata > rowmax)) begin
          rowmax <= tbl_rdata;
          best   <= rd_row_act;
        end
      end

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + TW'(1);
          if (clr_addr == TW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          scan_cnt <= '0;
          if (in_acc) begin
            row_base   <= row_base_next;
            reward_q   <= reward;
            terminal_q <= terminal;
            force_q    <= force_action;
            forced_q   <= forced_mod[forced_action];
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_cnt == '0) begin
            old_val <= tbl_rdata;
          end
          scan_cnt <= scan_cnt + AW'(1);
          if (scan_cnt == AW'(NUM_ACTIONS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_MUL_T;
        end
        ST_MUL_T: begin
          prod1 <= P1_W'($signed({1'b0, gam})) * P1_W'(rowmax);
          if (force_q) begin
            best <= forced_q;
          end
          state <= ST_ADD_T;
        end
        ST_ADD_T: begin
          diff  <= DIFF_W'(reward_q) + DIFF_W'(r1) - DIFF_W'(old_val);
          state <= ST_MUL_D;
        end
        ST_MUL_D: begin
          prod2 <= P2_W'($signed({1'b0, learn_rate})) * P2_W'(diff);
          state <= ST_RND;
        end
        ST_RND: begin
          delta <= rsum2[P2_W-1:FRAC_W];
          state <= ST_WB;
        end
        ST_WB: begin
          if (wb_go) begin
            out_valid     <= 1'b1;
            chosen_action <= best;
            row_maximum   <= rowmax;
            updated_value <= nv_sat;
            saturated     <= sat_hi || sat_lo;
            last_addr     <= row_base + TW'(best);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TQL_ASSERT_SAME(a_write_source, clk, rst, tbl_we, (state == ST_CLEAR) || (state == ST_WB))
  `TQL_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_acc, (state == ST_SCAN) && (scan_cnt == '0))
  `TQL_ASSERT_SAME(a_result_from_wb, clk, rst, $rose(out_valid), $past(state == ST_WB))
  `TQL_ASSERT_NEXT(a_wb_returns_idle, clk, rst, wb_go, (state == ST_IDLE) && out_valid)

endmodule

// ----- sv/tql_table.sv -----
module tql_table #(
  parameter int DEPTH  = tql_pkg::NUM_STATES_DEF * tql_pkg::NUM_ACTIONS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic signed [tql_pkg::VAL_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic signed [tql_pkg::VAL_W-1:0]  rd_data
);
  import tql_pkg::*;

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
